// File: rtl/rdc_pkg.sv
// Shared types and constants for the radix digit converter.
`timescale 1ns / 1ps

package rdc_pkg;

  localparam int unsigned ValueBits  = 10;
  localparam int unsigned RadixBits  = 4;
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned StackDepth = 10;
  localparam int unsigned LevelBits  = $clog2(StackDepth + 1);
  localparam int unsigned CntBits    = $clog2(ValueBits);
  localparam logic [RadixBits-1:0] MinRadix = RadixBits'(2);
  localparam logic [RadixBits-1:0] MaxRadix = RadixBits'(10);

  typedef struct packed {
    logic [ValueBits-1:0] value;
    logic [RadixBits-1:0] radix;
  } rdc_in_t;

  typedef struct packed {
    logic [DigitBits-1:0] digit;
    logic                 last;
    logic                 bad_radix;
    logic                 empty_res;
  } rdc_out_t;

endpackage

// File: rtl/radix_digit_converter.sv
// Top level: unsigned value to base-N digits, bit-serial division, digit stack.
`timescale 1ns / 1ps

// Usage:
//   Pulse start with an item on item_i while busy is low; the item is taken
//   at that edge. Results appear on result_o for one cycle each, marked by
//   result_valid_o, most significant digit first; last marks the final one.
//   The receiver cannot stall the results.
// Sequence:
//   A bad base or a zero value gives its single result in the cycle after the
//   item, and the block is ready again at once.
//   Otherwise each digit is the remainder of a full division by the base on
//   the shared restoring divider (one quotient bit per cycle); all digits are
//   divided out before the stack is popped, one digit per cycle. busy is high
//   from the cycle after acceptance until the last digit is shown; the next
//   item can be taken in the cycle of the last digit.
// Reset:
//   rst_ni clears the sequencer, the stack level and the result strobe; the
//   digit stack itself is not cleared.
module radix_digit_converter (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  rdc_pkg::rdc_in_t item_i,
  output logic             result_valid_o,
  output rdc_pkg::rdc_out_t result_o
);

  localparam int unsigned VB = rdc_pkg::ValueBits;
  localparam int unsigned LB = rdc_pkg::LevelBits;
  localparam int unsigned CB = rdc_pkg::CntBits;
  localparam int unsigned RB = rdc_pkg::RadixBits;
  localparam int unsigned DB = rdc_pkg::DigitBits;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDiv  = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  logic [1:0]    state_q, state_d;
  logic [VB-1:0] quo_q, quo_d;
  logic [RB-1:0] rem_q, rem_d;
  logic [RB-1:0] radix_q, radix_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [LB-1:0] level_q, level_d;
  logic          valid_q, valid_d;
  rdc_pkg::rdc_out_t res_q, res_d;

  logic [DB-1:0] stack_q [rdc_pkg::StackDepth];
  logic          push;

  // one restoring-division step
  logic [RB:0]   rem_sh;
  logic          ge;
  logic [RB-1:0] rem_nx;
  logic [VB-1:0] quo_nx;
  logic          accept;
  logic          radix_bad;
  logic [LB-1:0] level_m1;

  assign rem_sh   = {rem_q, quo_q[VB-1]};
  assign ge       = rem_sh >= {1'b0, radix_q};
  assign rem_nx   = ge ? RB'(rem_sh - {1'b0, radix_q}) : rem_sh[RB-1:0];
  assign quo_nx   = {quo_q[VB-2:0], ge};
  assign accept   = start && !busy;
  assign radix_bad = (item_i.radix < rdc_pkg::MinRadix) || (item_i.radix > rdc_pkg::MaxRadix);
  assign level_m1 = level_q - LB'(1);
  assign push     = (state_q == StDiv) && (cnt_q == CB'(VB - 1))
                    && (level_q < LB'(rdc_pkg::StackDepth));

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    cnt_d   = cnt_q;
    level_d = level_q;
    valid_d = 1'b0;
    res_d   = res_q;
    unique case (state_q)
      StIdle: begin
        if (accept) begin
          if (radix_bad) begin
            valid_d = 1'b1;
            res_d   = '{digit: '0, last: 1'b1, bad_radix: 1'b1, empty_res: 1'b0};
          end else if (item_i.value == '0) begin
            valid_d = 1'b1;
            res_d   = '{digit: '0, last: 1'b1, bad_radix: 1'b0, empty_res: 1'b1};
          end else begin
            quo_d   = item_i.value;
            rem_d   = '0;
            radix_d = item_i.radix;
            cnt_d   = '0;
            level_d = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        quo_d = quo_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q + CB'(1);
        if (cnt_q == CB'(VB - 1)) begin
          cnt_d = '0;
          rem_d = '0;
          if (push) level_d = level_q + LB'(1);
          // quotient exhausted: all digits are on the stack
          if (quo_nx == '0) state_d = StEmit;
        end
      end
      StEmit: begin
        valid_d = 1'b1;
        res_d   = '{digit: stack_q[level_m1], last: (level_q == LB'(1)),
                    bad_radix: 1'b0, empty_res: 1'b0};
        level_d = level_m1;
        if (level_q == LB'(1)) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      level_q <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      level_q <= level_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
    res_q   <= res_d;
    if (push) stack_q[level_q] <= rem_nx;
  end

  assign busy           = (state_q != StIdle);
  assign result_valid_o = valid_q;
  assign result_o       = res_q;

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.bad_radix || result_o.empty_res) |-> result_o.last)
    else $error("error or empty result without last");

  a_quiet_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StDiv |-> !result_valid_o)
    else $error("result shown while dividing");

  a_emit_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StEmit |-> (level_q != '0) && (level_q <= LB'(rdc_pkg::StackDepth)))
    else $error("stack level out of range while emitting");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy)
    else $error("last result while still busy");

endmodule

// File: tb/tb_radix_digit_converter.sv
// Testbench for radix_digit_converter: directed and random items, digit-by-digit checks.
`timescale 1ns / 1ps

module tb_radix_digit_converter;

  localparam int unsigned RandomItems = 330;
  localparam int unsigned QuietTail   = 40;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  rdc_pkg::rdc_in_t  item_i = '0;
  logic              result_valid_o;
  rdc_pkg::rdc_out_t result_o;

  rdc_pkg::rdc_in_t  items_to_send[$];
  rdc_pkg::rdc_out_t digits_due[$];

  int unsigned gap_left = 0;
  int unsigned items_taken = 0;
  int unsigned items_total = 0;
  int unsigned digits_seen = 0;
  int unsigned bad_seen = 0;
  int unsigned empty_seen = 0;
  int unsigned mismatches = 0;

  radix_digit_converter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Push the expected digit stream of one accepted item, most significant first.
  function automatic void expand_digits(rdc_pkg::rdc_in_t it);
    logic [rdc_pkg::ValueBits-1:0] n;
    logic [rdc_pkg::ValueBits-1:0] base;
    logic [rdc_pkg::DigitBits-1:0] stack[$];
    rdc_pkg::rdc_out_t             r;
    r = '0;
    if (it.radix < rdc_pkg::MinRadix || it.radix > rdc_pkg::MaxRadix) begin
      r.last      = 1'b1;
      r.bad_radix = 1'b1;
      digits_due.push_back(r);
      return;
    end
    if (it.value == '0) begin
      r.last      = 1'b1;
      r.empty_res = 1'b1;
      digits_due.push_back(r);
      return;
    end
    n    = it.value;
    base = rdc_pkg::ValueBits'(it.radix);
    while (n != '0) begin
      // only the low StackDepth digits survive a full stack
      if (stack.size() < rdc_pkg::StackDepth) stack.push_back(rdc_pkg::DigitBits'(n % base));
      n = n / base;
    end
    while (stack.size() > 0) begin
      r.digit = stack.pop_back();
      r.last  = (stack.size() == 0);
      digits_due.push_back(r);
    end
  endfunction

  task automatic add_item(input int unsigned value, input int unsigned radix);
    rdc_pkg::rdc_in_t it;
    it.value = rdc_pkg::ValueBits'(value);
    it.radix = rdc_pkg::RadixBits'(radix);
    items_to_send.push_back(it);
  endtask

  // Driver: offers the queue head on start until it is taken, pausing for random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expand_digits(item_i);
        void'(items_to_send.pop_front());
        items_taken++;
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (items_to_send.size() > QuietTail && ((items_taken / 50) % 2 == 0) &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 14);
        start <= 1'b0;
      end else if (items_to_send.size() > 0) begin
        start  <= 1'b1;
        item_i <= items_to_send[0];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result must match the oldest expected digit.
  always @(posedge clk_i) begin
    rdc_pkg::rdc_out_t want;
    if (rst_ni && result_valid_o) begin
      if (digits_due.size() == 0) begin
        $error("unexpected result: digit %0d last %0b bad_radix %0b empty_res %0b",
               result_o.digit, result_o.last, result_o.bad_radix, result_o.empty_res);
        mismatches++;
      end else begin
        want = digits_due.pop_front();
        if (result_o.digit !== want.digit) begin
          $error("digit: expected %0d, got %0d", want.digit, result_o.digit);
          mismatches++;
        end
        if (result_o.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result_o.last);
          mismatches++;
        end
        if (result_o.bad_radix !== want.bad_radix) begin
          $error("bad_radix: expected %0b, got %0b", want.bad_radix, result_o.bad_radix);
          mismatches++;
        end
        if (result_o.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, result_o.empty_res);
          mismatches++;
        end
        if (want.bad_radix) bad_seen++;
        else if (want.empty_res) empty_seen++;
        else digits_seen++;
      end
    end
  end

  initial begin
    int unsigned pick;
    int unsigned radix;
    int unsigned value;

    // base out of range wins over zero value
    add_item(0, 0);
    add_item(0, 1);
    add_item(0, 11);
    add_item(1023, 15);
    add_item(5, 1);
    // zero value with valid bases
    add_item(0, 2);
    add_item(0, 10);
    // all-ones value in every valid base
    for (int b = 2; b <= 10; b++) add_item(1023, b);
    add_item(1, 2);
    add_item(9, 10);
    add_item(10, 10);
    add_item(512, 2);
    add_item(999, 10);
    add_item(6, 7);

    for (int i = 0; i < RandomItems; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        radix = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1) : $urandom_range(11, 15);
      end else begin
        radix = $urandom_range(rdc_pkg::MinRadix, rdc_pkg::MaxRadix);
      end
      pick = $urandom_range(0, 99);
      if (pick < 8) value = 0;
      else if (pick < 30) value = $urandom_range(1, 31);
      else value = $urandom_range(0, (1 << rdc_pkg::ValueBits) - 1);
      add_item(value, radix);
    end
    items_total = items_to_send.size();

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (items_to_send.size() > 0 || digits_due.size() > 0);
    repeat (20) @(posedge clk_i);

    $display("Ran %0d items through the converter, bases 0 to 15, values 0 to 1023.",
             items_taken);
    $display("Checked %0d digits, %0d bad-base and %0d zero-value results.",
             digits_seen, bad_seen, empty_seen);
    if (mismatches == 0 && items_taken == items_total) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d items unsent, %0d results outstanding",
             items_to_send.size(), digits_due.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
